/* sv/hte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hte_pkg
// shared types, character codes and lookup functions for the html text
// extractor
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int TAG_LOOKAHEAD       = 8;
  localparam int ENTITY_SPAN_DEFAULT = 8;
  localparam int MAX_RESULTS         = 17;
  localparam int WIN_CW              = $clog2(TAG_LOOKAHEAD + 1);
  localparam int EMIT_CW             = $clog2(MAX_RESULTS + 1);

  // character codes
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  // tag patterns, lower case, first character in the top byte
  localparam logic [55:0] PAT_SCRIPT     = "<script";
  localparam logic [47:0] PAT_STYLE      = "<style";
  localparam logic [63:0] PAT_END_SCRIPT = "</script";
  localparam logic [55:0] PAT_END_STYLE  = "</style";

  typedef struct packed {
    logic [7:0] in_byte;
    logic       doc_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       doc_end;
    logic       run_last;
  } text_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic [WIN_CW-1:0] count;
    logic [7:0]        head;
    logic              open_hit;
    logic              close_hit;
  } win_stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } ent_hit_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'd32) : c;
  endfunction

  // exact-case match of the held entity name against the known names
  function automatic ent_hit_t ent_lookup(input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [7:0] b3, input logic [7:0] b4,
                                          input logic [4:0] len);
    ent_hit_t r;
    r.hit   = 1'b1;
    r.value = CH_SPACE;
    if (len == 5'd2 && {b1, b2} == "lt") begin
      r.value = CH_LT;
    end else if (len == 5'd2 && {b1, b2} == "gt") begin
      r.value = CH_GT;
    end else if (len == 5'd3 && {b1, b2, b3} == "amp") begin
      r.value = CH_AMP;
    end else if (len == 5'd3 && {b1, b2, b3} == "reg") begin
      r.value = CH_SPACE;
    end else if (len == 5'd4 && {b1, b2, b3, b4} == "quot") begin
      r.value = CH_QUOT;
    end else if (len == 5'd4 && {b1, b2, b3, b4} == "nbsp") begin
      r.value = CH_SPACE;
    end else if (len == 5'd4 && {b1, b2, b3, b4} == "apos") begin
      r.value = CH_APOS;
    end else if (len == 5'd4 && {b1, b2, b3, b4} == "copy") begin
      r.value = CH_SPACE;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/hte_tag_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hte_tag_window
// eight-byte lookahead window with case-insensitive script and style tag match
// ----------------------------------------------------------------------------
module hte_tag_window (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hte_pkg::win_ctrl_t ctrl,
  input  wire logic [7:0]        data,
  output hte_pkg::win_stat_t     stat
);

  localparam int N   = hte_pkg::TAG_LOOKAHEAD;
  localparam int IW  = $clog2(N);
  localparam int CW  = hte_pkg::WIN_CW;

  logic [7:0]    win [N];
  logic [CW-1:0] count;
  logic [7:0]    lw  [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CW'(1);
    end else if (ctrl.pop) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      win[count[IW-1:0]] <= data;
    end else if (ctrl.pop && !ctrl.clear) begin
      for (int i = 0; i < N - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      lw[i] = hte_pkg::lower_case(win[i]);
    end
  end

  assign stat.count    = count;
  assign stat.head     = win[0];
  assign stat.open_hit = (count >= CW'(N - 1)) &&
                         (({lw[0], lw[1], lw[2], lw[3], lw[4], lw[5], lw[6]}
                           == hte_pkg::PAT_SCRIPT) ||
                          ({lw[0], lw[1], lw[2], lw[3], lw[4], lw[5]}
                           == hte_pkg::PAT_STYLE));
  assign stat.close_hit = (count >= CW'(N)) &&
                          (({lw[0], lw[1], lw[2], lw[3], lw[4], lw[5], lw[6], lw[7]}
                            == hte_pkg::PAT_END_SCRIPT) ||
                           ({lw[0], lw[1], lw[2], lw[3], lw[4], lw[5], lw[6]}
                            == hte_pkg::PAT_END_STYLE));

endmodule
`default_nettype wire

/* sv/html_text_extractor_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// html_text_extractor_top
// streaming html to plain text: tag strip, entity decode, whitespace collapse
// ----------------------------------------------------------------------------
// One html byte is taken per item and the extracted text comes out as a
// stream of result items; run_last marks the last result caused by an input
// item and doc_end the last result of a document. A byte leaves the eight-byte
// tag window only once the window is full, so most items give no result or
// one, and an item carrying doc_last drains the window and the entity buffer,
// always gives at least one result (a bare end marker if there is no text)
// and returns the block to its reset state. A small sequencer drives one
// entity queue, one name compare and one whitespace unit, one step per cycle
// unless the output stalls: an ordinary byte goes through accept, window
// step, entity step, entity check and wrap-up (only accept, window check
// and wrap-up while the window is still filling, no entity steps when the
// byte popped gives no text), a decoded entity then has its bytes, '&' and
// ';' included, retired from the queue, and a failed entity replays its
// held bytes one per cycle; as a replayed '&' can open an entity that fails
// again, a byte can be replayed more than once. An item with doc_last adds
// a window step, and the entity steps it causes, for each byte still in the
// window, then flushes the bytes left in the entity buffer. The input is not
// ready while an item is at work; a full output register with text_ready low
// stalls the sequencer. No clearing pass after reset.
// ----------------------------------------------------------------------------
module html_text_extractor_top #(
  parameter int ENTITY_SPAN = hte_pkg::ENTITY_SPAN_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                html_valid,
  output logic                     html_ready,
  input  wire hte_pkg::in_item_t   html,
  output logic                     text_valid,
  input  wire logic                text_ready,
  output hte_pkg::text_item_t      text
);

  // entity queue: held entity bytes at the front, bytes waiting for the
  // entity stage behind them
  localparam int QD  = ENTITY_SPAN + 1;
  localparam int QIW = $clog2(QD);
  localparam int CW  = $clog2(QD + 1);
  localparam int EW  = hte_pkg::EMIT_CW;
  localparam int WCW = hte_pkg::WIN_CW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STRIP = 3'd1;
  localparam logic [2:0] ST_ENT   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state, state_next;
  logic          last_item, last_item_next;
  logic [CW-1:0] ent_count, ent_count_next;    // held entity bytes, '&' included
  logic [CW-1:0] pend_count, pend_count_next;  // bytes waiting behind them
  logic [CW-1:0] drop_count, drop_count_next;  // front bytes still to retire
  logic          inside_tag, inside_tag_next;
  logic          skip_content, skip_content_next;
  logic          prev_space, prev_space_next;
  logic          hold_valid, hold_valid_next;
  logic [7:0]    hold_byte, hold_byte_next;
  logic [EW-1:0] n_emit, n_emit_next;
  logic          out_valid;
  hte_pkg::text_item_t out_data;

  logic [7:0]    ent_q [QD];
  logic          q_wr, q_shift;
  logic [7:0]    q_wr_data;

  hte_pkg::win_ctrl_t wctl;
  hte_pkg::win_stat_t wstat;

  logic [7:0]        ent_c;
  hte_pkg::ent_hit_t ent_match;
  logic              emit_req;
  logic [7:0]        emit_ch;
  logic              ch_space, room, put, out_free, done_need, go;
  logic [7:0]        put_byte;
  logic              out_load;
  hte_pkg::text_item_t out_load_data;
  logic              strip_more;

  hte_tag_window u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (wctl),
    .data (html.in_byte),
    .stat (wstat)
  );

  // byte at the head of the waiting part and the name compare on the held bytes
  assign ent_c     = ent_q[ent_count[QIW-1:0]];
  assign ent_match = hte_pkg::ent_lookup(ent_q[1], ent_q[2], ent_q[3], ent_q[4],
                                         5'(ent_count) - 5'd1);

  // a window byte is due: the window is full, or the document is draining
  assign strip_more = last_item ? (wstat.count != '0)
                                : (wstat.count == WCW'(hte_pkg::TAG_LOOKAHEAD));

  // which character goes to the whitespace unit this cycle
  always_comb begin
    emit_req = 1'b0;
    emit_ch  = hte_pkg::CH_SPACE;
    unique case (state)
      ST_ENT: begin
        if (drop_count == '0 && pend_count != '0) begin
          if (ent_count == '0) begin
            if (ent_c != hte_pkg::CH_AMP) begin
              emit_req = 1'b1;
              emit_ch  = ent_c;
            end
          end else if (ent_c == hte_pkg::CH_SEMI && ent_match.hit) begin
            emit_req = 1'b1;
            emit_ch  = ent_match.value;
          end else if (ent_c != hte_pkg::CH_SEMI && ent_count < CW'(ENTITY_SPAN)) begin
            emit_req = 1'b0;
          end else begin
            // failed entity: the '&' goes out literally, the rest is replayed
            emit_req = 1'b1;
            emit_ch  = hte_pkg::CH_AMP;
          end
        end
      end
      ST_FLUSH: begin
        if (ent_count != '0) begin
          emit_req = 1'b1;
          emit_ch  = ent_q[0];
        end
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // whitespace collapse; one result is held back so run_last can be marked
  assign ch_space  = hte_pkg::is_space(emit_ch);
  assign room      = n_emit < EW'(hte_pkg::MAX_RESULTS);
  assign put       = emit_req && (!ch_space || !prev_space) && room;
  assign put_byte  = ch_space ? hte_pkg::CH_SPACE : emit_ch;
  assign out_free  = !out_valid || text_ready;
  assign done_need = (state == ST_DONE) && (hold_valid || last_item);
  assign go        = out_free || !((put && hold_valid) || done_need);

  always_comb begin
    state_next        = state;
    last_item_next    = last_item;
    ent_count_next    = ent_count;
    pend_count_next   = pend_count;
    drop_count_next   = drop_count;
    inside_tag_next   = inside_tag;
    skip_content_next = skip_content;
    prev_space_next   = prev_space;
    hold_valid_next   = hold_valid;
    hold_byte_next    = hold_byte;
    n_emit_next       = n_emit;
    out_load          = 1'b0;
    out_load_data     = '{text_byte: hold_byte, byte_valid: 1'b1,
                          doc_end: 1'b0, run_last: 1'b0};
    q_wr              = 1'b0;
    q_shift           = 1'b0;
    q_wr_data         = wstat.head;
    wctl              = '0;

    if (go) begin
      if (emit_req) begin
        prev_space_next = ch_space;
        if (put) begin
          n_emit_next     = n_emit + EW'(1);
          hold_byte_next  = put_byte;
          hold_valid_next = 1'b1;
          out_load        = hold_valid;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (html_valid) begin
            wctl.push      = 1'b1;
            last_item_next = html.doc_last;
            state_next     = ST_STRIP;
          end
        end

        ST_STRIP: begin
          if (strip_more) begin
            wctl.pop = 1'b1;
            if (wstat.head == hte_pkg::CH_LT) begin
              inside_tag_next = 1'b1;
              if (wstat.open_hit) begin
                skip_content_next = 1'b1;
              end
              if (wstat.close_hit) begin
                skip_content_next = 1'b0;
              end
            end else if (wstat.head == hte_pkg::CH_GT) begin
              // a closing bracket always reads as a space
              inside_tag_next = 1'b0;
              q_wr            = 1'b1;
              q_wr_data       = hte_pkg::CH_SPACE;
              pend_count_next = CW'(1);
              state_next      = ST_ENT;
            end else if (!inside_tag && !skip_content) begin
              q_wr            = 1'b1;
              pend_count_next = CW'(1);
              state_next      = ST_ENT;
            end
          end else begin
            state_next = last_item ? ST_FLUSH : ST_DONE;
          end
        end

        ST_ENT: begin
          if (drop_count != '0) begin
            // retire the bytes of a decoded entity
            q_shift         = 1'b1;
            drop_count_next = drop_count - CW'(1);
          end else if (pend_count == '0) begin
            state_next = last_item ? ST_STRIP : ST_DONE;
          end else if (ent_count == '0) begin
            if (ent_c == hte_pkg::CH_AMP) begin
              ent_count_next = CW'(1);
            end else begin
              q_shift = 1'b1;
            end
            pend_count_next = pend_count - CW'(1);
          end else if (ent_c == hte_pkg::CH_SEMI && ent_match.hit) begin
            drop_count_next = ent_count + CW'(1);
            ent_count_next  = '0;
            pend_count_next = pend_count - CW'(1);
          end else if (ent_c != hte_pkg::CH_SEMI && ent_count < CW'(ENTITY_SPAN)) begin
            ent_count_next  = ent_count + CW'(1);
            pend_count_next = pend_count - CW'(1);
          end else begin
            // drop the '&' and rescan everything behind it
            q_shift         = 1'b1;
            pend_count_next = pend_count + ent_count - CW'(1);
            ent_count_next  = '0;
          end
        end

        ST_FLUSH: begin
          // document end: held entity bytes go out literally
          if (ent_count != '0) begin
            q_shift        = 1'b1;
            ent_count_next = ent_count - CW'(1);
          end else begin
            state_next = ST_DONE;
          end
        end

        ST_DONE: begin
          if (hold_valid) begin
            out_load        = 1'b1;
            out_load_data   = '{text_byte: hold_byte, byte_valid: 1'b1,
                                doc_end: last_item, run_last: 1'b1};
            hold_valid_next = 1'b0;
          end else if (last_item) begin
            // bare end marker
            out_load      = 1'b1;
            out_load_data = '{text_byte: 8'h00, byte_valid: 1'b0,
                              doc_end: 1'b1, run_last: 1'b1};
          end
          n_emit_next = '0;
          state_next  = ST_IDLE;
          if (last_item) begin
            wctl.clear        = 1'b1;
            inside_tag_next   = 1'b0;
            skip_content_next = 1'b0;
            ent_count_next    = '0;
            prev_space_next   = 1'b1;
          end
        end

        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_item    <= 1'b0;
      ent_count    <= '0;
      pend_count   <= '0;
      drop_count   <= '0;
      inside_tag   <= 1'b0;
      skip_content <= 1'b0;
      prev_space   <= 1'b1;
      hold_valid   <= 1'b0;
      n_emit       <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      last_item    <= last_item_next;
      ent_count    <= ent_count_next;
      pend_count   <= pend_count_next;
      drop_count   <= drop_count_next;
      inside_tag   <= inside_tag_next;
      skip_content <= skip_content_next;
      prev_space   <= prev_space_next;
      hold_valid   <= hold_valid_next;
      n_emit       <= n_emit_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (text_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  // entity queue: one write or one shift towards the front per cycle
  always_ff @(posedge clk) begin
    if (q_wr) begin
      ent_q[ent_count[QIW-1:0]] <= q_wr_data;
    end else if (q_shift) begin
      for (int i = 0; i < QD - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

  assign html_ready = (state == ST_IDLE);
  assign text_valid = out_valid;
  assign text       = out_data;

endmodule
`default_nettype wire

/* sim/html_text_extractor_top_tb.sv */
// ----------------------------------------------------------------------------
// html_text_extractor_top_tb
// self-checking bench for the streaming html to plain text extractor
// ----------------------------------------------------------------------------
// Feeds html documents byte by byte and keeps its own model of the three
// stages: tag window, entity decode and whitespace collapse. Each accepted
// input item queues the text items it should cause, and every text item that
// leaves the block is checked field by field against the oldest one queued.
// Short directed documents come first, then a long receiver hold-off that
// fills the block, then random html-like documents with random idling on
// both sides, and a last stretch with no idling at all.
// ----------------------------------------------------------------------------
module html_text_extractor_top_tb;

  localparam int ENT_SPAN     = hte_pkg::ENTITY_SPAN_DEFAULT;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 500000;

  typedef logic [7:0] bytes_t[$];

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                html_valid = 1'b0;
  logic                html_ready;
  hte_pkg::in_item_t   html = '0;
  logic                text_valid;
  logic                text_ready = 1'b0;
  hte_pkg::text_item_t text;

  // run control shared by the sender, the receiver and the tests
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  // model state: tag window, entity buffer (with its leading '&'), collapse flag
  logic [7:0] tag_win [hte_pkg::TAG_LOOKAHEAD];
  int         win_fill;
  bit         in_tag;
  bit         skipping;
  bit         prev_space;
  logic [7:0] ent_held [$];
  logic [7:0] item_text [$];
  hte_pkg::text_item_t expected_text [$];

  string      ent_names [8] = '{"amp", "lt", "gt", "quot", "nbsp", "apos", "copy", "reg"};
  logic [7:0] ent_values [8] = '{hte_pkg::CH_AMP, hte_pkg::CH_LT, hte_pkg::CH_GT,
                                 hte_pkg::CH_QUOT, hte_pkg::CH_SPACE, hte_pkg::CH_APOS,
                                 hte_pkg::CH_SPACE, hte_pkg::CH_SPACE};

  html_text_extractor_top DUT (
    .clk        (clk),
    .rst        (rst),
    .html_valid (html_valid),
    .html_ready (html_ready),
    .html       (html),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_state();
    win_fill   = 0;
    in_tag     = 1'b0;
    skipping   = 1'b0;
    prev_space = 1'b1;
    ent_held.delete();
  endfunction

  // whitespace collapse: a run of 9..13 or space becomes one space
  function automatic void collapse_byte(input logic [7:0] c);
    if (c == hte_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
      if (!prev_space && item_text.size() < hte_pkg::MAX_RESULTS)
        item_text = {item_text, hte_pkg::CH_SPACE};
      prev_space = 1'b1;
    end else begin
      if (item_text.size() < hte_pkg::MAX_RESULTS)
        item_text = {item_text, c};
      prev_space = 1'b0;
    end
  endfunction

  // exact-case lookup of the name held after the '&'
  function automatic bit entity_value(output logic [7:0] v);
    int i;
    int j;
    bit same;
    v = '0;
    for (i = 0; i < 8; i++) begin
      if (ent_names[i].len() == ent_held.size() - 1) begin
        same = 1'b1;
        for (j = 0; j < ent_names[i].len(); j++)
          if (ent_names[i][j] != ent_held[j + 1]) same = 1'b0;
        if (same) begin
          v = ent_values[i];
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // entity stage; a failed match puts the held name bytes back in front of
  // the work list so that a later '&' among them can open a new entity
  function automatic void decode_byte(input logic [7:0] c);
    logic [7:0] work [$];
    logic [7:0] b;
    logic [7:0] v;
    int k;
    work = {work, c};
    while (work.size() > 0) begin
      b = work.pop_front();
      if (ent_held.size() == 0) begin
        if (b == hte_pkg::CH_AMP) ent_held = {ent_held, b};
        else collapse_byte(b);
      end else if (b == hte_pkg::CH_SEMI && entity_value(v)) begin
        ent_held.delete();
        collapse_byte(v);
      end else if (b != hte_pkg::CH_SEMI && ent_held.size() < ENT_SPAN) begin
        ent_held = {ent_held, b};
      end else begin
        work.push_front(b);
        for (k = ent_held.size() - 1; k >= 1; k--) work.push_front(ent_held[k]);
        ent_held.delete();
        collapse_byte(hte_pkg::CH_AMP);
      end
    end
  endfunction

  // case-blind compare of the window head against a tag pattern
  function automatic bit window_holds(input string pat);
    logic [7:0] b;
    int k;
    for (k = 0; k < pat.len(); k++) begin
      b = tag_win[k];
      if (b >= 8'h41 && b <= 8'h5a) b = b + 8'd32;
      if (b != pat[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // tag stage: retire the window head, win_fill bytes being present
  function automatic void strip_step();
    int k;
    if (tag_win[0] == hte_pkg::CH_LT) begin
      in_tag = 1'b1;
      // near the end of a document the patterns are only tried with enough bytes
      if (win_fill >= hte_pkg::TAG_LOOKAHEAD - 1 &&
          (window_holds("<script") || window_holds("<style")))
        skipping = 1'b1;
      if (win_fill >= hte_pkg::TAG_LOOKAHEAD &&
          (window_holds("</script") || window_holds("</style")))
        skipping = 1'b0;
    end else if (tag_win[0] == hte_pkg::CH_GT) begin
      in_tag = 1'b0;
      decode_byte(hte_pkg::CH_SPACE);
    end else if (!in_tag && !skipping) begin
      decode_byte(tag_win[0]);
    end
    for (k = 0; k < hte_pkg::TAG_LOOKAHEAD - 1; k++) tag_win[k] = tag_win[k + 1];
    win_fill--;
  endfunction

  // queue the text items that one accepted html item should cause
  function automatic void predict_text(input logic [7:0] b, input logic last);
    hte_pkg::text_item_t r;
    int k;
    item_text.delete();
    tag_win[win_fill] = b;
    win_fill++;
    if (!last) begin
      if (win_fill == hte_pkg::TAG_LOOKAHEAD) strip_step();
    end else begin
      // flush: drain the window, then whatever the entity buffer holds goes on literally
      while (win_fill > 0) strip_step();
      for (k = 0; k < ent_held.size(); k++) collapse_byte(ent_held[k]);
      ent_held.delete();
    end
    for (k = 0; k < item_text.size(); k++) begin
      r.text_byte  = item_text[k];
      r.byte_valid = 1'b1;
      r.run_last   = (k == item_text.size() - 1);
      r.doc_end    = last && r.run_last;
      expected_text = {expected_text, r};
    end
    if (last && item_text.size() == 0) begin
      // a document with no text still closes with a bare end marker
      r          = '0;
      r.doc_end  = 1'b1;
      r.run_last = 1'b1;
      expected_text = {expected_text, r};
    end
    if (last) clear_state();
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic void put_str(ref bytes_t q, input string s);
    int k;
    for (k = 0; k < s.len(); k++) q = {q, s[k]};
  endfunction

  function automatic string mixed_case(input string s);
    string r;
    int k;
    r = s;
    for (k = 0; k < r.len(); k++)
      if (r[k] >= "a" && r[k] <= "z" && $urandom_range(0, 1)) r[k] = r[k] - 8'd32;
    return r;
  endfunction

  // an html-like document built from random fragments
  function automatic void make_doc(ref bytes_t doc);
    int frags;
    int f;
    int k;
    int n;
    logic [7:0] b;
    doc.delete();
    frags = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    for (f = 0; f < frags; f++) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++)
            case ($urandom_range(0, 2))
              0:       doc = {doc, 8'($urandom_range(97, 122))};
              1:       doc = {doc, 8'($urandom_range(65, 90))};
              default: doc = {doc, 8'($urandom_range(48, 57))};
            endcase
        end
        2: begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            b = 8'($urandom_range(8, 13));
            doc = {doc, (b == 8'd8) ? hte_pkg::CH_SPACE : b};
          end
        end
        3: begin
          case ($urandom_range(0, 5))
            0:       put_str(doc, "<p>");
            1:       put_str(doc, "<div class=a>");
            2:       put_str(doc, "</b>");
            3:       put_str(doc, "<br/>");
            4:       put_str(doc, "<scrip>");
            default: put_str(doc, "<st>");
          endcase
        end
        4: begin
          // script or style block, closer sometimes of the other kind or missing
          if ($urandom_range(0, 1)) put_str(doc, mixed_case("<script"));
          else put_str(doc, mixed_case("<style"));
          if ($urandom_range(0, 1)) put_str(doc, " type=t");
          put_str(doc, ">a < b &amp; c");
          case ($urandom_range(0, 3))
            0:       put_str(doc, mixed_case("</style>"));
            1, 2:    put_str(doc, mixed_case("</script>"));
            default: ;
          endcase
        end
        5, 6: begin
          doc = {doc, hte_pkg::CH_AMP};
          put_str(doc, ent_names[$urandom_range(0, 7)]);
          doc = {doc, hte_pkg::CH_SEMI};
        end
        7: begin
          // broken entity: random name, semicolon maybe out of reach or missing
          doc = {doc, hte_pkg::CH_AMP};
          n = $urandom_range(0, 9);
          for (k = 0; k < n; k++) doc = {doc, 8'($urandom_range(97, 122))};
          if ($urandom_range(0, 1)) doc = {doc, hte_pkg::CH_SEMI};
        end
        8: begin
          doc = {doc, hte_pkg::CH_AMP};
          put_str(doc, mixed_case(ent_names[$urandom_range(0, 7)]));
          doc = {doc, hte_pkg::CH_SEMI};
        end
        9: begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) doc = {doc, 8'($urandom_range(0, 255))};
        end
        10: begin
          case ($urandom_range(0, 3))
            0:       doc = {doc, hte_pkg::CH_GT};
            1:       doc = {doc, hte_pkg::CH_LT};
            2:       doc = {doc, hte_pkg::CH_AMP};
            default: doc = {doc, hte_pkg::CH_SEMI};
          endcase
        end
        default: begin
          // an entity opened inside a failed one
          if ($urandom_range(0, 1)) put_str(doc, "&&");
          else put_str(doc, "&a&");
          put_str(doc, ent_names[$urandom_range(0, 7)]);
          doc = {doc, hte_pkg::CH_SEMI};
        end
      endcase
    end
    if (doc.size() == 0) doc = {doc, 8'h78};
  endfunction

  // offer one html item, hold it until taken, then predict its text
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      html_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    html_valid <= 1'b1;
    html       <= '{in_byte: b, doc_last: last};
    @(posedge clk);
    while (!html_ready) @(posedge clk);
    predict_text(b, last);
  endtask

  task automatic send_str(input string s, input bit end_doc);
    int k;
    for (k = 0; k < s.len(); k++) send_item(s[k], end_doc && k == s.len() - 1);
  endtask

  // receiver: random stalls, or one long hold-off when a test asks for it
  initial begin : text_sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        text_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        text_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        text_ready <= 1'b0;
        repeat (n) @(posedge clk);
        text_ready <= 1'b1;
      end else begin
        text_ready <= 1'b1;
      end
    end
  end

  // every text item taken is checked against the oldest one queued
  always @(posedge clk) begin : text_check
    hte_pkg::text_item_t want;
    if (!rst && text_valid && text_ready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected text item %h, none expected", $time, text);
        fail_count++;
      end else begin
        want = expected_text.pop_front();
        if (text.text_byte !== want.text_byte) begin
          $display("%0t: text_byte expected %h got %h", $time, want.text_byte, text.text_byte);
          fail_count++;
        end
        if (text.byte_valid !== want.byte_valid) begin
          $display("%0t: byte_valid expected %b got %b", $time, want.byte_valid,
                   text.byte_valid);
          fail_count++;
        end
        if (text.doc_end !== want.doc_end) begin
          $display("%0t: doc_end expected %b got %b", $time, want.doc_end, text.doc_end);
          fail_count++;
        end
        if (text.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.run_last, text.run_last);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------- tests

  // empty documents give a bare end marker; byte extremes pass straight through
  task automatic test_doc_ends();
    send_item(hte_pkg::CH_SPACE, 1'b1);
    send_item(hte_pkg::CH_LT, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
  endtask

  // mixed-case style block skipped, every '>' turned into a space
  task automatic test_tags();
    send_str("<sTyle>a</STYLE>b", 1'b1);
  endtask

  // case-sensitive names, '&' restarting an entity, an entity left open at the end
  task automatic test_entities();
    send_str("&LT;&&gt;&quot;&nbsp", 1'b1);
  endtask

  // receiver holds off while plain text keeps coming, so the block backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_str("backed up text, still coming in ok", 1'b1);
  endtask

  task automatic test_random_docs(input int n_items);
    bytes_t doc;
    int sent;
    int k;
    sent = 0;
    while (sent < n_items) begin
      make_doc(doc);
      for (k = 0; k < doc.size(); k++) send_item(doc[k], k == doc.size() - 1);
      sent += doc.size();
    end
  endtask

  initial begin
    clear_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_doc_ends();
    test_tags();
    test_entities();
    test_backpressure();
    test_random_docs(220);
    // last stretch at full rate on both sides
    idle_on = 1'b0;
    test_random_docs(70);

    html_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
